>>> design/emps_pkg.sv
package emps_pkg;

	// register widths and reset values
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_W-1:0] PAUSE_RESET = 16'd100;
	localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [CFG_W-1:0] CYCLE_PAUSE_RESET = 16'd2000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_PAUSE = 2'd2;

	// output field widths
	localparam int VOLT_W = 20;
	localparam int CURR_W = 23;
	localparam int POWER_W = 16;
	localparam int ENERGY_W = 24;

	// request and reply codes share one encoding
	typedef enum logic [2:0] {
		FR_NONE = 3'd0,
		FR_ADDR = 3'd1,
		FR_VOLT = 3'd2,
		FR_CURR = 3'd3,
		FR_POWER = 3'd4,
		FR_ENERGY = 3'd5
	} frame_code_t;

	// classified input word
	typedef enum logic {
		ITEM_BYTE = 1'b0,
		ITEM_TICK = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] pause_ticks;
		logic [CFG_W-1:0] reply_timeout_ticks;
		logic [CFG_W-1:0] cycle_pause_ticks;
	} cfg_t;

endpackage

>>> design/emps_ifs.sv
interface emps_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [7:0] rx_byte;

	modport source(output valid, command, rx_byte, input ready);
	modport sink(input valid, command, rx_byte, output ready);
endinterface

interface emps_out_if import emps_pkg::*; ();
	logic valid;
	logic ready;
	frame_code_t send_frame;
	frame_code_t update_kind;
	logic [VOLT_W-1:0] voltage_tenths;
	logic [CURR_W-1:0] current_hundredths;
	logic [POWER_W-1:0] power_watts;
	logic [ENERGY_W-1:0] energy_wh;

	modport source(output valid, send_frame, update_kind, voltage_tenths,
		current_hundredths, power_watts, energy_wh, input ready);
	modport sink(input valid, send_frame, update_kind, voltage_tenths,
		current_hundredths, power_watts, energy_wh, output ready);
endinterface

>>> design/energy_meter_poll_sequencer_top.sv
// Energy meter poll sequencer.
// The item channel carries one word per received serial byte (command 0,
// rx_byte valid) or per elapsed timer tick (command 1). The result channel
// returns exactly one word for each item: the request frame to transmit now,
// the reply that was handled, and the stored voltage, current, power and
// energy readings.
// Throughput is one item per cycle while the receiver takes results; the
// back end handles each item with a combinational scaling multiply.
// An item is registered in the queue and then in the result register
// before its result is valid.
// A two-entry queue sits between the input side and the sequencer, and the
// result sits in an output register. When the receiver stalls, the result
// holds, the queue fills its two entries, then item ready drops.
// Configuration is a plain write port: cfg_we with cfg_index 0 pause ticks,
// 1 reply timeout ticks, 2 pause ticks between polls; others are ignored.
// Reset clears the queue and measurements, loads the default timings and
// leaves the timer expired, so the first item sends a set-address request.
module energy_meter_poll_sequencer_top import emps_pkg::*; #(
	parameter int FRAME_LEN = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	emps_in_if.sink              item,
	emps_out_if.source           result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t  cfg_q;
	logic  q_valid;
	logic  q_ready;
	item_t q_item;

	// timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pause_ticks <= PAUSE_RESET;
			cfg_q.reply_timeout_ticks <= TIMEOUT_RESET;
			cfg_q.cycle_pause_ticks <= CYCLE_PAUSE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAUSE: cfg_q.pause_ticks <= cfg_data;
				REG_TIMEOUT: cfg_q.reply_timeout_ticks <= cfg_data;
				REG_CYCLE_PAUSE: cfg_q.cycle_pause_ticks <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	emps_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item)
	);

	emps_back #(
		.FRAME_LEN(FRAME_LEN)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item),
		.result(result)
	);

endmodule

>>> design/emps_front.sv
module emps_front import emps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	emps_in_if.sink    item,
	output logic       q_valid,
	input  logic       q_ready,
	output item_t      q_item
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	item_t      in_item;

	// classify the incoming word
	always_comb begin
		in_item.kind = item.command ? ITEM_TICK : ITEM_BYTE;
		in_item.data = item.rx_byte;
	end

	assign item.ready = (count_q != 2'd2);
	assign push = item.valid && item.ready;
	assign q_valid = (count_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rd_ptr_q];

	// two-entry queue toward the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

	// fill level matches the pointer distance
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue count out of step with pointers");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with empty or full");

endmodule

>>> design/emps_back.sv
module emps_back import emps_pkg::*; #(
	parameter int FRAME_LEN = 7
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_valid,
	output logic       q_ready,
	input  item_t      q_item,
	emps_out_if.source result
);

	localparam int FIDX_W = $clog2(FRAME_LEN);

	typedef enum logic [3:0] {
		PH_ADDR = 4'd0,
		PH_PAUSE1 = 4'd1,
		PH_VOLT = 4'd2,
		PH_PAUSE2 = 4'd3,
		PH_CURR = 4'd4,
		PH_PAUSE3 = 4'd5,
		PH_POWER = 4'd6,
		PH_PAUSE4 = 4'd7,
		PH_ENERGY = 4'd8
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [FIDX_W-1:0]   fidx_q, fidx_n;
	logic [7:0]          fb_q [3];
	logic [7:0]          fb_w [3];
	logic [CFG_W-1:0]    cd_q, cd_n;
	logic [VOLT_W-1:0]   volt_q, volt_n;
	logic [CURR_W-1:0]   curr_q, curr_n;
	logic [POWER_W-1:0]  power_q, power_n;
	logic [ENERGY_W-1:0] energy_q, energy_n;
	frame_code_t         send, upd;
	logic                out_valid_q;
	logic                fire;
	logic                is_byte;
	logic                frame_done;
	logic [15:0]         word;
	logic [VOLT_W-1:0]   volt_calc;
	logic [CURR_W-1:0]   curr_calc;

	assign fire = q_valid && (!out_valid_q || result.ready);
	assign q_ready = !out_valid_q || result.ready;
	assign is_byte = (q_item.kind == ITEM_BYTE);
	assign frame_done = is_byte && (fidx_q == FIDX_W'(FRAME_LEN - 1));

	// frame bytes one to three as they stand after this word
	always_comb begin
		fb_w[0] = (is_byte && fidx_q == FIDX_W'(1)) ? q_item.data : fb_q[0];
		fb_w[1] = (is_byte && fidx_q == FIDX_W'(2)) ? q_item.data : fb_q[1];
		fb_w[2] = (is_byte && fidx_q == FIDX_W'(3)) ? q_item.data : fb_q[2];
	end

	// fixed-point scaling of the reply word
	assign word = {fb_w[0], fb_w[1]};
	assign volt_calc = VOLT_W'(word) * VOLT_W'(10) + VOLT_W'(fb_w[2]);
	assign curr_calc = CURR_W'(word) * CURR_W'(100) + CURR_W'(fb_w[2]);

	// per-word sequencing: timer, frame handling, then request
	always_comb begin
		phase_n = phase_q;
		fidx_n = fidx_q;
		cd_n = cd_q;
		volt_n = volt_q;
		curr_n = curr_q;
		power_n = power_q;
		energy_n = energy_q;
		upd = FR_NONE;
		send = FR_NONE;

		if (!is_byte) begin
			if (cd_q != '0) cd_n = cd_q - CFG_W'(1);
		end else if (frame_done) begin
			fidx_n = '0;
			unique case (phase_q)
				PH_ADDR: begin
					cd_n = cfg.pause_ticks;
					phase_n = PH_PAUSE1;
					upd = FR_ADDR;
				end
				PH_VOLT: begin
					volt_n = volt_calc;
					cd_n = cfg.pause_ticks;
					phase_n = PH_PAUSE2;
					upd = FR_VOLT;
				end
				PH_CURR: begin
					curr_n = curr_calc;
					cd_n = cfg.pause_ticks;
					phase_n = PH_PAUSE3;
					upd = FR_CURR;
				end
				PH_POWER: begin
					power_n = word;
					cd_n = cfg.pause_ticks;
					phase_n = PH_PAUSE4;
					upd = FR_POWER;
				end
				PH_ENERGY: begin
					energy_n = {fb_w[0], fb_w[1], fb_w[2]};
					cd_n = cfg.cycle_pause_ticks;
					phase_n = PH_PAUSE1;
					upd = FR_ENERGY;
				end
				default: upd = FR_NONE;
			endcase
		end else begin
			fidx_n = fidx_q + FIDX_W'(1);
		end

		// expired timer: next request, or restart on reply timeout
		if (cd_n == '0) begin
			cd_n = cfg.reply_timeout_ticks;
			unique case (phase_n)
				PH_PAUSE1: begin
					phase_n = PH_VOLT;
					send = FR_VOLT;
				end
				PH_PAUSE2: begin
					phase_n = PH_CURR;
					send = FR_CURR;
				end
				PH_PAUSE3: begin
					phase_n = PH_POWER;
					send = FR_POWER;
				end
				PH_PAUSE4: begin
					phase_n = PH_ENERGY;
					send = FR_ENERGY;
				end
				default: begin
					phase_n = PH_ADDR;
					fidx_n = '0;
					send = FR_ADDR;
				end
			endcase
		end
	end

	// sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ADDR;
			fidx_q <= '0;
			fb_q[0] <= '0;
			fb_q[1] <= '0;
			fb_q[2] <= '0;
			cd_q <= '0;
			volt_q <= '0;
			curr_q <= '0;
			power_q <= '0;
			energy_q <= '0;
			out_valid_q <= 1'b0;
			result.send_frame <= FR_NONE;
			result.update_kind <= FR_NONE;
			result.voltage_tenths <= '0;
			result.current_hundredths <= '0;
			result.power_watts <= '0;
			result.energy_wh <= '0;
		end else begin
			if (fire) begin
				phase_q <= phase_n;
				fidx_q <= fidx_n;
				fb_q <= fb_w;
				cd_q <= cd_n;
				volt_q <= volt_n;
				curr_q <= curr_n;
				power_q <= power_n;
				energy_q <= energy_n;
				out_valid_q <= 1'b1;
				result.send_frame <= send;
				result.update_kind <= upd;
				result.voltage_tenths <= volt_n;
				result.current_hundredths <= curr_n;
				result.power_watts <= power_n;
				result.energy_wh <= energy_n;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid = out_valid_q;

	// frame index never reaches the frame length
	assert property (@(posedge clk) disable iff (!arst_n)
		fidx_q <= FIDX_W'(FRAME_LEN - 1))
		else $error("frame index past end of frame");

	// a set-address request leaves an empty frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && send == FR_ADDR) |=> (fidx_q == '0 && phase_q == PH_ADDR))
		else $error("set address did not restart the frame");

	// a tick moves the frame index only when it starts a set-address request
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !is_byte && send != FR_ADDR) |=> (fidx_q == $past(fidx_q)))
		else $error("tick moved the frame index");

	// a handled reply is reported with its own code
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && upd != FR_NONE) |=> (result.valid && result.update_kind == $past(upd)))
		else $error("reply code lost on the way out");

endmodule
